// File: src/e2q_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle to quaternion unit.
package e2q_pkg;

    // Port widths of the angle inputs and quaternion outputs.
    localparam int ANG_W             = 13;
    localparam int OUT_W             = 16;
    localparam int DEF_OUT_FRAC_BITS = 15;

    // Pipeline shape of one sine and cosine path.
    localparam int N_CELLS      = 6;
    localparam int CELL_STAGES  = 3;
    localparam int FRONT_STAGES = 4;
    localparam int SC_LAT       = FRONT_STAGES + N_CELLS * CELL_STAGES + 1;
    localparam int PROD_STAGES  = 4;

    // One in unsigned Q1.30.
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Half-angle units: a quarter turn is 1800 codes, a full turn 7200.
    localparam logic [13:0] TURN_UNITS    = 14'd7200;
    localparam logic [13:0] QUARTER_UNITS = 14'd1800;

    // Radian scaling: pi in Q2.30 over 3600 is 937016 plus 1826/3600.
    localparam logic [19:0] RAD_INT  = 20'd937016;
    localparam logic [10:0] RAD_FRAC = 11'd1826;
    localparam logic [21:0] RAD_RND  = 22'd1800;
    // Reciprocal of 3600 scaled by 2^34, rounded up.
    localparam logic [22:0] RAD_RECIP = 23'd4772186;

    // Context carried alongside the Horner terms along the chain.
    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] x;
        logic [31:0] x2;
    } t_angle_ctx;

    // Cosine divisor used by each cell of the chain.
    function automatic int unsigned cos_k(input int idx);
        int unsigned k;
        case (idx)
            0:       k = 132;
            1:       k = 90;
            2:       k = 56;
            3:       k = 30;
            4:       k = 12;
            default: k = 2;
        endcase
        return k;
    endfunction

    // Sine divisor used by each cell; the first cell has no sine step.
    function automatic int unsigned sin_k(input int idx);
        int unsigned k;
        case (idx)
            1:       k = 110;
            2:       k = 72;
            3:       k = 42;
            4:       k = 20;
            5:       k = 6;
            default: k = 2;
        endcase
        return k;
    endfunction

    // Sign-magnitude Q2.30 product, rounded half up on the magnitude.
    function automatic logic signed [31:0] q30_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        neg = a[31] ^ b[31];
        ua  = a[31] ? 32'(-a) : 32'(a);
        ub  = b[31] ? 32'(-b) : 32'(b);
        p   = (64'(ua[30:0]) * 64'(ub[30:0]) + (64'd1 << 29)) >> 30;
        return neg ? -$signed(32'(p)) : $signed(32'(p));
    endfunction

endpackage

// File: src/e2q_horner_unit.sv
// One Horner step t' = ONE - round(x2 * t / (K * 2^30)) in three pipeline stages.
module e2q_horner_unit #(
    parameter int unsigned K = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_t,
    output logic [30:0] o_t
);
    import e2q_pkg::*;

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
    localparam logic [63:0] BIAS  = 64'(K) << 29;
    localparam logic [7:0]  KW    = 8'(K);

    logic [62:0] r_prod;
    logic [31:0] r_m;
    logic [30:0] r_q0;
    logic [30:0] r_t;
    logic [31:0] n_m;
    logic [39:0] rem;
    logic [31:0] term;

    // Product scaled down by 2^30 with a bias of K/2; its quotient estimate by reciprocal is at most one short.
    assign n_m = 32'((64'(r_prod) + BIAS) >> 30);

    // Correct the estimate and subtract from one.
    always_comb begin
        rem  = 40'(r_m) - 40'(r_q0) * 40'(KW);
        term = (rem >= 40'(KW)) ? 32'(r_q0) + 32'd1 : 32'(r_q0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 63'(i_x2) * 63'(i_t);
            r_m    <= n_m;
            r_q0   <= 31'((64'(n_m) * 64'(RECIP)) >> 32);
            r_t    <= (term > 32'(Q30_ONE)) ? 31'd0 : 31'(32'(Q30_ONE) - term);
        end
    end

    assign o_t = r_t;

endmodule

// File: src/e2q_horner_cell.sv
// One cell of the series chain: a cosine step, a sine step and the carried context.
module e2q_horner_cell #(
    parameter int unsigned KC     = 2,
    parameter int unsigned KS     = 2,
    parameter bit          SIN_EN = 1'b1
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  e2q_pkg::t_angle_ctx   i_ctx,
    input  logic [30:0]           i_ts,
    input  logic [30:0]           i_tc,
    output e2q_pkg::t_angle_ctx   o_ctx,
    output logic [30:0]           o_ts,
    output logic [30:0]           o_tc
);
    import e2q_pkg::*;

    t_angle_ctx r_ctx [CELL_STAGES];

    // Context moves along with the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int i = 1; i < CELL_STAGES; i++) begin
                r_ctx[i] <= r_ctx[i-1];
            end
        end
    end
    assign o_ctx = r_ctx[CELL_STAGES-1];

    // Cosine step.
    e2q_horner_unit #(.K(KC)) u_cos (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x2  (i_ctx.x2),
        .i_t   (i_tc),
        .o_t   (o_tc)
    );

    // Sine step, or a matched delay where this cell has none.
    if (SIN_EN) begin : g_sin
        e2q_horner_unit #(.K(KS)) u_sin (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (i_ctx.x2),
            .i_t   (i_ts),
            .o_t   (o_ts)
        );
    end else begin : g_sin_dly
        logic [30:0] r_ts [CELL_STAGES];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ts[0] <= i_ts;
                for (int i = 1; i < CELL_STAGES; i++) begin
                    r_ts[i] <= r_ts[i-1];
                end
            end
        end
        assign o_ts = r_ts[CELL_STAGES-1];
    end

endmodule

// File: src/e2q_sincos.sv
// Sine and cosine of one half-angle: range reduction, radian scaling and the cell chain.
module e2q_sincos (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [e2q_pkg::ANG_W-1:0]  i_angle,
    output logic signed [31:0]                o_sin,
    output logic signed [31:0]                o_cos
);
    import e2q_pkg::*;

    logic signed [13:0] v_ext;
    logic [13:0]        n_h;
    logic [1:0]         n_quad;
    logic [10:0]        n_r;
    logic [21:0]        n_n;

    logic [1:0]  r_quad [FRONT_STAGES];
    logic [10:0] r_r;
    logic [30:0] r_hi;
    logic [10:0] r_lo;
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [30:0] r_x4;

    t_angle_ctx  ctx [N_CELLS+1];
    logic [30:0] ts  [N_CELLS+1];
    logic [30:0] tc  [N_CELLS+1];

    logic [30:0]        s_mag;
    logic signed [31:0] s_sgn;
    logic signed [31:0] c_sgn;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    // Reduce the code to one turn, then split into quadrant and remainder.
    always_comb begin
        v_ext = {i_angle[ANG_W-1], i_angle};
        n_h   = i_angle[ANG_W-1] ? 14'(v_ext + $signed(TURN_UNITS)) : 14'(v_ext);
        if (n_h < QUARTER_UNITS) begin
            n_quad = 2'd0;
            n_r    = 11'(n_h);
        end else if (n_h < 14'(2 * QUARTER_UNITS)) begin
            n_quad = 2'd1;
            n_r    = 11'(n_h - QUARTER_UNITS);
        end else if (n_h < 14'(3 * QUARTER_UNITS)) begin
            n_quad = 2'd2;
            n_r    = 11'(n_h - 14'(2 * QUARTER_UNITS));
        end else begin
            n_quad = 2'd3;
            n_r    = 11'(n_h - 14'(3 * QUARTER_UNITS));
        end
    end

    // Fractional part of the radian scaling, rounded.
    assign n_n = 22'(22'(r_r) * 22'(RAD_FRAC) + RAD_RND);

    // Front stages: remainder, radian parts, radians, radians squared.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad[0] <= n_quad;
            for (int i = 1; i < FRONT_STAGES; i++) begin
                r_quad[i] <= r_quad[i-1];
            end
            r_r  <= n_r;
            r_hi <= 31'(31'(r_r) * 31'(RAD_INT));
            r_lo <= 11'((45'(n_n) * 45'(RAD_RECIP)) >> 34);
            r_x  <= r_hi + 31'(r_lo);
            r_x2 <= 32'((62'(r_x) * 62'(r_x) + (62'd1 << 29)) >> 30);
            r_x4 <= r_x;
        end
    end

    assign ctx[0] = '{quad: r_quad[FRONT_STAGES-1], x: r_x4, x2: r_x2};
    assign ts[0]  = Q30_ONE;
    assign tc[0]  = Q30_ONE;

    // The series chain, one Horner step per cell.
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        e2q_horner_cell #(
            .KC     (cos_k(g)),
            .KS     (sin_k(g)),
            .SIN_EN (g > 0)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_ctx (ctx[g]),
            .i_ts  (ts[g]),
            .i_tc  (tc[g]),
            .o_ctx (ctx[g+1]),
            .o_ts  (ts[g+1]),
            .o_tc  (tc[g+1])
        );
    end

    // Final sine product and quadrant mapping.
    always_comb begin
        s_mag = 31'((62'(ctx[N_CELLS].x) * 62'(ts[N_CELLS]) + (62'd1 << 29)) >> 30);
        s_sgn = $signed({1'b0, s_mag});
        c_sgn = $signed({1'b0, tc[N_CELLS]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (ctx[N_CELLS].quad)
                2'd0: begin
                    r_sin <= s_sgn;
                    r_cos <= c_sgn;
                end
                2'd1: begin
                    r_sin <= c_sgn;
                    r_cos <= -s_sgn;
                end
                2'd2: begin
                    r_sin <= -s_sgn;
                    r_cos <= -c_sgn;
                end
                default: begin
                    r_sin <= -c_sgn;
                    r_cos <= s_sgn;
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// File: src/euler_to_quaternion_unit.sv
// An input transfer passes the front stages, the series cells, the quadrant register and the product stages.
// Throughput: one sample per cycle while the output is not stalled; the pipeline is a fixed chain of series cells.
// A held result under output stall freezes the whole pipeline, input included.
// Reset clears the stage valid flags only; the data path carries no reset.
// Reset takes effect at the next rising clock edge while i_rst_n is low.
module euler_to_quaternion_unit #(
    parameter int OUT_FRAC_BITS = e2q_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [e2q_pkg::ANG_W-1:0]  i_roll_tenths,
    input  logic signed [e2q_pkg::ANG_W-1:0]  i_pitch_tenths,
    input  logic signed [e2q_pkg::ANG_W-1:0]  i_heading_tenths,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [e2q_pkg::OUT_W-1:0]  o_quat_w,
    output logic signed [e2q_pkg::OUT_W-1:0]  o_quat_x,
    output logic signed [e2q_pkg::OUT_W-1:0]  o_quat_y,
    output logic signed [e2q_pkg::OUT_W-1:0]  o_quat_z
);
    import e2q_pkg::*;

    localparam int LAT = SC_LAT + PROD_STAGES;
    localparam int SH  = 30 - OUT_FRAC_BITS;
    localparam int RSH = (SH > 0) ? SH : 1;
    localparam int LSH = (SH < 0) ? -SH : 0;

    logic           en;
    logic [LAT-1:0] r_vld;

    logic signed [31:0] sr, cr, sp, cp, sy, cy;
    logic signed [31:0] r_crcp, r_srsp, r_srcp, r_crsp, r_cy1, r_sy1;
    logic signed [31:0] r_t [8];
    logic signed [32:0] r_sum [4];
    logic signed [OUT_W-1:0] r_q [4];

    // Rescale a Q2.30 sum to the output format and saturate.
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [32:0] v);
        logic        neg;
        logic [33:0] m;
        neg = v[32];
        m   = neg ? 34'(-v) : 34'(v);
        if (SH > 0) begin
            m = (m + (34'd1 << (RSH - 1))) >> RSH;
        end else begin
            m = m << LSH;
        end
        if (neg) begin
            return (m >= 34'd32768) ? -16'sd32768 : -$signed(16'(m));
        end else begin
            return (m > 34'd32767) ? 16'sd32767 : $signed(16'(m));
        end
    endfunction

    // The whole pipeline advances unless a held result is stalled.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Half-angle sine and cosine for each axis.
    e2q_sincos u_roll (
        .i_clk (i_clk), .i_en (en), .i_angle (i_roll_tenths), .o_sin (sr), .o_cos (cr)
    );
    e2q_sincos u_pitch (
        .i_clk (i_clk), .i_en (en), .i_angle (i_pitch_tenths), .o_sin (sp), .o_cos (cp)
    );
    e2q_sincos u_head (
        .i_clk (i_clk), .i_en (en), .i_angle (i_heading_tenths), .o_sin (sy), .o_cos (cy)
    );

    // Pair products, triple products, sums and output rounding.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crcp <= q30_mul(cr, cp);
            r_srsp <= q30_mul(sr, sp);
            r_srcp <= q30_mul(sr, cp);
            r_crsp <= q30_mul(cr, sp);
            r_cy1  <= cy;
            r_sy1  <= sy;

            r_t[0] <= q30_mul(r_crcp, r_cy1);
            r_t[1] <= q30_mul(r_srsp, r_sy1);
            r_t[2] <= q30_mul(r_srcp, r_cy1);
            r_t[3] <= q30_mul(r_crsp, r_sy1);
            r_t[4] <= q30_mul(r_crsp, r_cy1);
            r_t[5] <= q30_mul(r_srcp, r_sy1);
            r_t[6] <= q30_mul(r_crcp, r_sy1);
            r_t[7] <= q30_mul(r_srsp, r_cy1);

            r_sum[0] <= 33'(r_t[0]) + 33'(r_t[1]);
            r_sum[1] <= 33'(r_t[2]) - 33'(r_t[3]);
            r_sum[2] <= 33'(r_t[4]) + 33'(r_t[5]);
            r_sum[3] <= 33'(r_t[6]) - 33'(r_t[7]);

            for (int i = 0; i < 4; i++) begin
                r_q[i] <= to_out(r_sum[i]);
            end
        end
    end

    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];

    // A stall only ever comes from a held result.
    a_stall_needs_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("pipeline stalled without a result waiting");

    // While stalled the stage valid flags stay frozen.
    a_frozen_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved during an output stall");

    // An accepted input transfer enters the first stage.
    a_input_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted sample lost at pipeline entry");

endmodule

// File: tb/euler_to_quaternion_unit_tb.sv
// Self-checking testbench for the Euler angle to quaternion unit.
`timescale 1ns / 1ps

module euler_to_quaternion_unit_tb;
    import e2q_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int MAX_REPORTS    = 10;

    // One quaternion as it leaves the block.
    typedef struct packed {
        logic [OUT_W-1:0] w;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } t_quat;

    // One row of the directed table; the quaternion is typed in only where known.
    typedef struct {
        logic [ANG_W-1:0] roll;
        logic [ANG_W-1:0] pitch;
        logic [ANG_W-1:0] heading;
        bit               known;
        t_quat            quat;
    } t_attitude_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [ANG_W-1:0] i_roll_tenths = '0;
    logic signed [ANG_W-1:0] i_pitch_tenths = '0;
    logic signed [ANG_W-1:0] i_heading_tenths = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_quat_w;
    logic signed [OUT_W-1:0] o_quat_x;
    logic signed [OUT_W-1:0] o_quat_y;
    logic signed [OUT_W-1:0] o_quat_z;

    t_quat pending_quats[$];
    int    mismatch_count = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;
    int    quiet_cycles = 0;
    bit    draining = 1'b0;

    euler_to_quaternion_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_roll_tenths   (i_roll_tenths),
        .i_pitch_tenths  (i_pitch_tenths),
        .i_heading_tenths(i_heading_tenths),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_quat_w        (o_quat_w),
        .o_quat_x        (o_quat_x),
        .o_quat_y        (o_quat_y),
        .o_quat_z        (o_quat_z)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sign-magnitude Q2.30 product with the magnitude rounded half up.
    function automatic longint q30_product(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        p  = (ua * ub + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // One Horner step of the series; an oversized term clamps the result to zero.
    function automatic longint unsigned series_step(input longint unsigned x2,
                                                    input longint unsigned t,
                                                    input longint unsigned k);
        longint unsigned term;
        term = (x2 * t + (k << 29)) / (k << 30);
        return (term > 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - term;
    endfunction

    // Sine and cosine of a half-angle given by the raw 13-bit angle code.
    task automatic half_angle_sincos(input logic [ANG_W-1:0] code,
                                     output longint sin_q, output longint cos_q);
        longint          v;
        longint          h;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          c;
        int unsigned     quad;
        longint unsigned sin_div[5] = '{110, 72, 42, 20, 6};
        longint unsigned cos_div[6] = '{132, 90, 56, 30, 12, 2};
        v    = longint'($signed(code));
        h    = ((v % 7200) + 7200) % 7200;
        quad = 32'(h / 1800);
        rem  = h % 1800;
        x    = (rem * 64'd3373259426 + 64'd1800) / 64'd3600;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        t = 64'(Q30_ONE);
        for (int i = 0; i < 5; i++) t = series_step(x2, t, sin_div[i]);
        s = longint'((x * t + (64'd1 << 29)) >> 30);
        t = 64'(Q30_ONE);
        for (int i = 0; i < 6; i++) t = series_step(x2, t, cos_div[i]);
        c = longint'(t);
        case (quad)
            0: begin sin_q = s;  cos_q = c;  end
            1: begin sin_q = c;  cos_q = -s; end
            2: begin sin_q = -s; cos_q = -c; end
            default: begin sin_q = -c; cos_q = s; end
        endcase
    endtask

    // Rescale a Q2.30 sum to Q1.15, rounding half away from zero, then saturate.
    function automatic logic [OUT_W-1:0] to_q15(input longint v);
        longint unsigned m;
        longint          r;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (29 - DEF_OUT_FRAC_BITS))) >> (30 - DEF_OUT_FRAC_BITS);
        if (m > 40000) m = 40000;
        r = (v < 0) ? -longint'(m) : longint'(m);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[OUT_W-1:0];
    endfunction

    // Z-Y-X composition of the three half-angle rotations.
    task automatic predict_quat(input logic [ANG_W-1:0] roll, input logic [ANG_W-1:0] pitch,
                                input logic [ANG_W-1:0] heading, output t_quat q);
        longint sr, cr, sp, cp, sy, cy;
        half_angle_sincos(roll, sr, cr);
        half_angle_sincos(pitch, sp, cp);
        half_angle_sincos(heading, sy, cy);
        q.w = to_q15(q30_product(q30_product(cr, cp), cy) + q30_product(q30_product(sr, sp), sy));
        q.x = to_q15(q30_product(q30_product(sr, cp), cy) - q30_product(q30_product(cr, sp), sy));
        q.y = to_q15(q30_product(q30_product(cr, sp), cy) + q30_product(q30_product(sr, cp), sy));
        q.z = to_q15(q30_product(q30_product(cr, cp), sy) - q30_product(q30_product(sr, sp), cy));
    endtask

    // Present one attitude sample and hold it until its transfer.
    task automatic send_attitude(input t_attitude_row row);
        t_quat q;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_roll_tenths    <= row.roll;
        i_pitch_tenths   <= row.pitch;
        i_heading_tenths <= row.heading;
        do @(posedge i_clk); while (o_stall);
        if (row.known) q = row.quat;
        else predict_quat(row.roll, row.pitch, row.heading, q);
        pending_quats.push_back(q);
    endtask

    // Random angle: mostly the nominal range, sometimes any 13-bit code.
    function automatic logic [ANG_W-1:0] random_angle();
        int a;
        if ($urandom_range(3) == 0) return ANG_W'($urandom);
        a = int'($urandom_range(7200)) - 3600;
        return a[ANG_W-1:0];
    endfunction

    // Receiver: random stall, and each result transfer checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_quat got;
        t_quat want;
        if (o_valid && !i_stall && i_rst_n) begin
            got = {o_quat_w, o_quat_x, o_quat_y, o_quat_z};
            if (pending_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result transfer: w=%0d x=%0d y=%0d z=%0d",
                             o_quat_w, o_quat_x, o_quat_y, o_quat_z);
            end else begin
                want = pending_quats.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                                 $signed(want.w), $signed(want.x), $signed(want.y), $signed(want.z),
                                 o_quat_w, o_quat_x, o_quat_y, o_quat_z);
                end
            end
        end
        i_stall <= (!draining && $urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else if (i_valid || pending_quats.size() != 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("euler_to_quaternion_unit_tb: FAIL");
            $finish;
        end
    end

    // Directed rows, then random phases with varying idle and stall rates.
    initial begin
        t_attitude_row directed[$];
        t_attitude_row row;
        int idle_set[4];
        int stall_set[4];

        idle_set  = '{0, 79, 0, 11};
        stall_set = '{0, 0, 79, 11};

        // Level attitude gives the identity; saturated at plus one.
        directed.push_back('{13'sd0, 13'sd0, 13'sd0, 1'b1, t_quat'({16'sd32767, 16'sd0, 16'sd0, 16'sd0})});
        // A full turn of roll flips the quaternion sign to minus one.
        directed.push_back('{13'sd3600, 13'sd0, 13'sd0, 1'b1, t_quat'({-16'sd32768, 16'sd0, 16'sd0, 16'sd0})});
        directed.push_back('{-13'sd3600, 13'sd0, 13'sd0, 1'b1, t_quat'({-16'sd32768, 16'sd0, 16'sd0, 16'sd0})});
        // Half a turn about one axis puts plus one on that axis alone.
        directed.push_back('{13'sd1800, 13'sd0, 13'sd0, 1'b1, t_quat'({16'sd0, 16'sd32767, 16'sd0, 16'sd0})});
        directed.push_back('{13'sd0, 13'sd1800, 13'sd0, 1'b1, t_quat'({16'sd0, 16'sd0, 16'sd32767, 16'sd0})});
        directed.push_back('{13'sd0, 13'sd0, 13'sd1800, 1'b1, t_quat'({16'sd0, 16'sd0, 16'sd0, 16'sd32767})});
        // Extremes of the field, codes outside the nominal range, then further angles.
        directed.push_back('{13'sd4095, 13'sd4095, 13'sd4095, 1'b0, '0});
        directed.push_back('{-13'sd4096, -13'sd4096, -13'sd4096, 1'b0, '0});
        directed.push_back('{-13'sd4096, 13'sd4095, 13'sd3600, 1'b0, '0});
        directed.push_back('{13'sd3601, -13'sd3601, 13'sd0, 1'b0, '0});
        directed.push_back('{-13'sd1800, -13'sd1800, -13'sd1800, 1'b0, '0});
        directed.push_back('{13'sd900, 13'sd900, 13'sd900, 1'b0, '0});
        directed.push_back('{13'sd1799, 13'sd1801, 13'sd2700, 1'b0, '0});
        directed.push_back('{13'sd1, -13'sd1, 13'sd3599, 1'b0, '0});
        directed.push_back('{13'sd3600, 13'sd3600, 13'sd3600, 1'b0, '0});
        directed.push_back('{13'sd450, -13'sd2700, 13'sd1234, 1'b0, '0});

        // Reset held low, then released.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_attitude(directed[i]);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                row.roll    = random_angle();
                row.pitch   = random_angle();
                row.heading = random_angle();
                row.known   = 1'b0;
                row.quat    = '0;
                send_attitude(row);
            end
        end
        i_valid <= 1'b0;

        // Drain the pipeline, then allow a few more cycles for stray results.
        draining = 1'b1;
        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_quats.size() == 0)
            $display("euler_to_quaternion_unit_tb: PASS");
        else
            $display("euler_to_quaternion_unit_tb: FAIL");
        $finish;
    end

endmodule
